[hdl/plcm_pkg.sv]
// Package for the piecewise-linear colormap: transfer structs, register
// codes, marker colors and pipeline constants. No dependencies.
`default_nettype none

package plcm_pkg;

  localparam int unsigned MAX_NODES_DEFAULT = 16;
  localparam int unsigned TABLE_SIZE        = 256;

  localparam int unsigned COLOR_W     = 24;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 24;

  // divider: 8-bit quotient, two bits resolved per stage
  localparam int unsigned QUOT_W         = 8;
  localparam int unsigned DIV_BITS_STAGE = 2;
  localparam int unsigned DIV_STAGES     = QUOT_W / DIV_BITS_STAGE;
  localparam int unsigned NUM_W          = 17;
  localparam int unsigned DSR_W          = 9;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTREME_EN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BELOW_MIN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ABOVE_MAX  = 2'd3;

  localparam logic [4:0]         NODE_COUNT_RST = 5'd2;
  localparam logic [COLOR_W-1:0] BELOW_MIN_RST  = 24'hBFBFBF;
  localparam logic [COLOR_W-1:0] ABOVE_MAX_RST  = 24'h000000;

  localparam logic [COLOR_W-1:0] MARK_A = 24'h000102;
  localparam logic [COLOR_W-1:0] MARK_B = 24'hFDFEFF;

  typedef struct packed {
    logic       mode;
    logic [3:0] node_slot;
    logic [7:0] node_position;
    logic [7:0] node_red;
    logic [7:0] node_green;
    logic [7:0] node_blue;
    logic [7:0] lookup_index;
  } item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       opaque;
  } result_t;

  function automatic logic is_marker(input logic [COLOR_W-1:0] c);
    return (c == MARK_A) || (c == MARK_B);
  endfunction

endpackage

`default_nettype wire

[hdl/piecewise_linear_colormap.sv]
// Piecewise-linear colormap top level: node store, segment search,
// interpolation multiply and pipelined restoring divider. Uses plcm_pkg.
//
//   channel   signals                          handshake
//   item in   item_i                           start high, busy low
//   result    result_o                         strobe_o, one cycle, no stall
//   config    cfg_idx_i, cfg_wdata_i           cfg_we_i, written at the edge
//
// One item enters per clock; busy stays low. A lookup's result passes
// through the input register, segment search, multiply, four divider
// stages (2 quotient bits each) and the output register. A node write
// goes into the store from the input register, so a lookup right behind
// it sees the new node. Reset clears the valid bits and the configuration
// registers; the node store holds no reset value.
`default_nettype none

module piecewise_linear_colormap
  import plcm_pkg::*;
#(
  parameter int unsigned MAX_NODES = MAX_NODES_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  item_t                 item_i,
  output logic                  strobe_o,
  output result_t               result_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned IDX_W   = $clog2(MAX_NODES);
  localparam int unsigned LATENCY = DIV_STAGES + 4;

  typedef struct packed {
    logic [COLOR_W-1:0] c1;
    logic [COLOR_W-1:0] c2;
    logic [7:0]         t;
    logic [7:0]         d;
    logic               ovr_lo;
    logic               ovr_hi;
  } sel_t;

  typedef struct packed {
    logic [2:0][NUM_W-1:0]  rem;
    logic [2:0][QUOT_W-1:0] quo;
    logic [DSR_W-1:0]       dsr;
    logic                   opaque;
    logic                   ovr_lo;
    logic                   ovr_hi;
  } div_t;

  // configuration
  logic [4:0]         node_count_q;
  logic               extreme_en_q;
  logic [COLOR_W-1:0] below_min_q;
  logic [COLOR_W-1:0] above_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
      extreme_en_q <= 1'b0;
      below_min_q  <= BELOW_MIN_RST;
      above_max_q  <= ABOVE_MAX_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NODE_COUNT: node_count_q <= cfg_wdata_i[4:0];
        CFG_EXTREME_EN: extreme_en_q <= cfg_wdata_i[0];
        CFG_BELOW_MIN:  below_min_q  <= cfg_wdata_i[COLOR_W-1:0];
        CFG_ABOVE_MAX:  above_max_q  <= cfg_wdata_i[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 0: input register
  logic  s0_valid_q;
  item_t s0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      s0_q <= item_i;
    end
  end

  // node store
  logic [7:0]         pos_q [MAX_NODES];
  logic [COLOR_W-1:0] col_q [MAX_NODES];
  logic               store_we;

  assign store_we = s0_valid_q && (s0_q.mode == MODE_WRITE) &&
                    (32'(s0_q.node_slot) < MAX_NODES);

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      pos_q[IDX_W'(s0_q.node_slot)] <= s0_q.node_position;
      col_q[IDX_W'(s0_q.node_slot)] <= {s0_q.node_red, s0_q.node_green, s0_q.node_blue};
    end
  end

  // stage 1: segment search, highest matching segment wins
  logic [7:0]       j;
  logic [IDX_W-1:0] last_idx;
  logic             s1_valid_q;
  sel_t             s1_d, s1_q;

  always_comb begin
    if (32'(s0_q.lookup_index) > TABLE_SIZE - 1) begin
      j = 8'(TABLE_SIZE - 1);
    end else begin
      j = s0_q.lookup_index;
    end

    if (node_count_q == 5'd0) begin
      last_idx = '0;
    end else if (32'(node_count_q) > MAX_NODES) begin
      last_idx = IDX_W'(MAX_NODES - 1);
    end else begin
      last_idx = IDX_W'(node_count_q - 5'd1);
    end

    // default: first node's color, flat
    s1_d.c1 = col_q[0];
    s1_d.c2 = col_q[0];
    s1_d.t  = 8'd0;
    s1_d.d  = 8'd1;
    for (int i = 0; i < MAX_NODES - 1; i++) begin
      if ((IDX_W'(i) < last_idx) && (pos_q[i] <= j) && (j < pos_q[i+1])) begin
        s1_d.c1 = col_q[i];
        s1_d.c2 = col_q[i+1];
        s1_d.t  = j - pos_q[i];
        s1_d.d  = pos_q[i+1] - pos_q[i];
      end
    end
    if (j >= pos_q[last_idx]) begin
      s1_d.c1 = col_q[last_idx];
      s1_d.c2 = col_q[last_idx];
      s1_d.t  = 8'd0;
      s1_d.d  = 8'd1;
    end

    s1_d.ovr_lo = extreme_en_q && (j == 8'd0);
    s1_d.ovr_hi = extreme_en_q && (32'(j) == TABLE_SIZE - 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s0_valid_q && (s0_q.mode == MODE_LOOKUP);
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  // stage 2: numerator a*(d-t) + b*t, then (2*num + d) over 2*d
  logic             dv_valid_q [DIV_STAGES+1];
  div_t             mul_d;
  div_t             dv_d       [1:DIV_STAGES];
  div_t             dv_q       [DIV_STAGES+1];
  logic [7:0]       w;
  logic [NUM_W-1:0] num [3];

  always_comb begin
    w = s1_q.d - s1_q.t;
    for (int k = 0; k < 3; k++) begin
      num[k] = NUM_W'(16'(s1_q.c1[COLOR_W-1-8*k -: 8] * w)) +
               NUM_W'(16'(s1_q.c2[COLOR_W-1-8*k -: 8] * s1_q.t));
      mul_d.rem[k] = NUM_W'({num[k][15:0], 1'b0}) + NUM_W'(s1_q.d);
      mul_d.quo[k] = '0;
    end
    mul_d.dsr    = {s1_q.d, 1'b0};
    mul_d.opaque = !((s1_q.c1 == s1_q.c2) && is_marker(s1_q.c1));
    mul_d.ovr_lo = s1_q.ovr_lo;
    mul_d.ovr_hi = s1_q.ovr_hi;
  end

  // stages 3..6: restoring division, two quotient bits per stage
  div_t             cur;
  logic [NUM_W-1:0] sh;

  always_comb begin
    cur = '0;
    sh  = '0;
    for (int g = 0; g < DIV_STAGES; g++) begin
      cur = dv_q[g];
      for (int s = 0; s < DIV_BITS_STAGE; s++) begin
        for (int k = 0; k < 3; k++) begin
          sh = NUM_W'(cur.dsr) << (QUOT_W - 1 - g * DIV_BITS_STAGE - s);
          if (cur.rem[k] >= sh) begin
            cur.rem[k] = cur.rem[k] - sh;
            cur.quo[k][QUOT_W - 1 - g * DIV_BITS_STAGE - s] = 1'b1;
          end
        end
      end
      dv_d[g+1] = cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g <= DIV_STAGES; g++) begin
        dv_valid_q[g] <= 1'b0;
      end
    end else begin
      dv_valid_q[0] <= s1_valid_q;
      for (int g = 1; g <= DIV_STAGES; g++) begin
        dv_valid_q[g] <= dv_valid_q[g-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q[0] <= mul_d;
    for (int g = 1; g <= DIV_STAGES; g++) begin
      dv_q[g] <= dv_d[g];
    end
  end

  // output stage: extreme colors override the interpolated one
  logic [COLOR_W-1:0] color;
  logic               strobe_q;
  result_t            result_q;

  always_comb begin
    color = {dv_q[DIV_STAGES].quo[0], dv_q[DIV_STAGES].quo[1], dv_q[DIV_STAGES].quo[2]};
    if (dv_q[DIV_STAGES].ovr_lo) begin
      color = below_min_q;
    end
    if (dv_q[DIV_STAGES].ovr_hi) begin
      color = above_max_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= dv_valid_q[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= {color, dv_q[DIV_STAGES].opaque};
  end

  assign strobe_o = strobe_q;
  assign result_o = result_q;

  // checks
  a_lookup_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (item_i.mode == MODE_LOOKUP) |-> ##LATENCY strobe_o)
    else $error("lookup transfer produced no result");

  a_result_has_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(start && !busy && (item_i.mode == MODE_LOOKUP), LATENCY))
    else $error("result without a matching lookup");

  a_segment_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (s1_q.t < s1_q.d))
    else $error("segment offset not below segment length");

  a_div_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_valid_q[DIV_STAGES] |->
      (dv_q[DIV_STAGES].rem[0] < NUM_W'(dv_q[DIV_STAGES].dsr)) &&
      (dv_q[DIV_STAGES].rem[1] < NUM_W'(dv_q[DIV_STAGES].dsr)) &&
      (dv_q[DIV_STAGES].rem[2] < NUM_W'(dv_q[DIV_STAGES].dsr)))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

[dv/piecewise_linear_colormap_tb.sv]
// Self-checking testbench for piecewise_linear_colormap: directed table, then random
// phases of node writes and lookups checked against an in-bench color predictor.
// Depends on plcm_pkg and the piecewise_linear_colormap RTL only.
`default_nettype none

module piecewise_linear_colormap_tb;
  import plcm_pkg::*;

  localparam int unsigned NODES           = MAX_NODES_DEFAULT;
  localparam int unsigned SLOT_W          = $clog2(NODES);
  localparam int unsigned PHASES          = 8;
  localparam int unsigned ITEMS_PER_PHASE = 95;
  localparam int unsigned DRAIN_CYCLES    = 12;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned MAX_PRINTS      = 40;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    item_t                 it;
    logic                  typed;
    result_t               want;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
  } stim_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  item_t                 item_i;
  logic                  strobe_o;
  result_t               result_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  // predictor copy of the node store and registers
  logic [7:0]         node_pos [NODES];
  logic [COLOR_W-1:0] node_rgb [NODES];
  logic [4:0]         nodes_used;
  logic               extremes_on;
  logic [COLOR_W-1:0] below_rgb;
  logic [COLOR_W-1:0] above_rgb;

  result_t     color_q [$];
  int unsigned mismatches  = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left  = 0;
  logic        gaps_on     = 1'b1;

  piecewise_linear_colormap i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .strobe_o    (strobe_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic marker_color(input logic [COLOR_W-1:0] c);
    return (c == MARK_A) || (c == MARK_B);
  endfunction

  function automatic logic [COLOR_W-1:0] blend(input logic [COLOR_W-1:0] c1,
                                               input logic [COLOR_W-1:0] c2,
                                               input int unsigned t, input int unsigned d);
    logic [COLOR_W-1:0] rgb;
    int unsigned        a, b, num, v;
    rgb = '0;
    for (int k = 0; k < 3; k++) begin
      a   = 32'(c1[16-8*k +: 8]);
      b   = 32'(c2[16-8*k +: 8]);
      num = a * (d - t) + b * t;
      v   = (2 * num + d) / (2 * d);
      if (v > 255) v = 255;
      rgb[16-8*k +: 8] = v[7:0];
    end
    return rgb;
  endfunction

  function automatic result_t lookup_color(input logic [7:0] idx);
    int unsigned        n, p1, p2, j;
    logic [COLOR_W-1:0] rgb, c1, c2;
    logic               op, hit;
    result_t            r;
    n = 32'(nodes_used);
    if (n < 1) n = 1;
    if (n > NODES) n = NODES;
    j = 32'(idx);
    if (j >= 32'(node_pos[SLOT_W'(n-1)])) begin
      rgb = node_rgb[SLOT_W'(n-1)];
      op  = !marker_color(rgb);
    end else begin
      hit = 1'b0;
      rgb = '0;
      op  = 1'b1;
      for (int unsigned i = 0; i + 1 < n; i++) begin
        p1 = 32'(node_pos[SLOT_W'(i)]);
        p2 = 32'(node_pos[SLOT_W'(i+1)]);
        if (p1 <= j && j < p2) begin
          c1  = node_rgb[SLOT_W'(i)];
          c2  = node_rgb[SLOT_W'(i+1)];
          rgb = blend(c1, c2, j - p1, p2 - p1);
          op  = !(c1 == c2 && marker_color(c1));
          hit = 1'b1;
        end
      end
      if (!hit) begin
        rgb = node_rgb[0];
        op  = !marker_color(rgb);
      end
    end
    if (extremes_on) begin
      if (j == 0) rgb = below_rgb;
      if (j == TABLE_SIZE - 1) rgb = above_rgb;
    end
    r = result_t'({rgb, op});
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  // result checker: the receiver never stalls, so every strobe is a transfer
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && strobe_o) begin
      if (color_q.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(result_o), 0);
      end else begin
        want = color_q.pop_front();
        if (result_o.red !== want.red)
          report_mismatch("red", 32'(result_o.red), 32'(want.red));
        if (result_o.green !== want.green)
          report_mismatch("green", 32'(result_o.green), 32'(want.green));
        if (result_o.blue !== want.blue)
          report_mismatch("blue", 32'(result_o.blue), 32'(want.blue));
        if (result_o.opaque !== want.opaque)
          report_mismatch("opaque", 32'(result_o.opaque), 32'(want.opaque));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || strobe_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input item_t it, input logic typed, input result_t want);
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (it.mode == MODE_WRITE) begin
      if (32'(it.node_slot) < NODES) begin
        node_pos[it.node_slot] = it.node_position;
        node_rgb[it.node_slot] = {it.node_red, it.node_green, it.node_blue};
      end
    end else begin
      color_q.push_back(typed ? want : lookup_color(it.lookup_index));
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (color_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (gaps_on) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  // node writes produce no result, so settle for the pipeline depth too
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_NODE_COUNT: nodes_used  = data[4:0];
      CFG_EXTREME_EN: extremes_on = data[0];
      CFG_BELOW_MIN:  below_rgb   = data[COLOR_W-1:0];
      CFG_ABOVE_MAX:  above_rgb   = data[COLOR_W-1:0];
      default: ;
    endcase
  endtask

  function automatic stim_row_t wr_row(input logic [3:0] slot, input logic [7:0] pos,
                                       input logic [COLOR_W-1:0] rgb);
    stim_row_t r;
    r = '0;
    r.kind             = ROW_ITEM;
    r.it.mode          = MODE_WRITE;
    r.it.node_slot     = slot;
    r.it.node_position = pos;
    {r.it.node_red, r.it.node_green, r.it.node_blue} = rgb;
    return r;
  endfunction

  function automatic stim_row_t lk_row(input logic [7:0] idx);
    stim_row_t r;
    r = '0;
    r.kind            = ROW_ITEM;
    r.it.mode         = MODE_LOOKUP;
    r.it.lookup_index = idx;
    return r;
  endfunction

  function automatic stim_row_t lk_is(input logic [7:0] idx, input logic [COLOR_W-1:0] rgb,
                                      input logic op);
    stim_row_t r;
    r       = lk_row(idx);
    r.typed = 1'b1;
    r.want  = result_t'({rgb, op});
    return r;
  endfunction

  function automatic stim_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r          = '0;
    r.kind     = ROW_CFG;
    r.cfg_idx  = idx;
    r.cfg_data = data;
    return r;
  endfunction

  function automatic logic [COLOR_W-1:0] pick_color(input logic [COLOR_W-1:0] prev);
    logic [COLOR_W-1:0] c;
    c = COLOR_W'($urandom);
    case ($urandom_range(0, 9))
      0: c = MARK_A;
      1: c = MARK_B;
      2: c = prev;
      default: ;
    endcase
    return c;
  endfunction

  function automatic item_t rand_item();
    logic [63:0]        raw;
    item_t              it;
    int unsigned        sel, s, lo, hi;
    logic [COLOR_W-1:0] c;
    raw = {$urandom, $urandom};
    it  = raw[$bits(item_t)-1:0];
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      it.mode = MODE_LOOKUP;
      case ($urandom_range(0, 7))
        0:    it.lookup_index = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        1, 2: it.lookup_index =
                8'(32'(node_pos[SLOT_W'($urandom_range(0, NODES - 1))]) +
                   $urandom_range(0, 2) - 1);
        default: ;
      endcase
    end else begin
      it.mode = MODE_WRITE;
      if (sel < 85) begin
        // keeps the store sorted around the rewritten slot
        s  = 32'(it.node_slot);
        lo = (s == 0) ? 0 : 32'(node_pos[SLOT_W'(s-1)]);
        hi = (s == NODES - 1) ? 255 : 32'(node_pos[SLOT_W'(s+1)]);
        it.node_position = 8'($urandom_range(lo, hi));
        c = pick_color(s == 0 ? COLOR_W'($urandom) : node_rgb[SLOT_W'(s-1)]);
        {it.node_red, it.node_green, it.node_blue} = c;
      end
    end
    return it;
  endfunction

  initial begin
    stim_row_t             dir_q [$];
    result_t               none;
    item_t                 it;
    int unsigned           p;
    logic [4:0]            nc;
    logic [CFG_DATA_W-1:0] wd, lo_rgb, hi_rgb;

    none        = '0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_NODE_COUNT;
    cfg_wdata_i = '0;
    nodes_used  = NODE_COUNT_RST;
    extremes_on = 1'b0;
    below_rgb   = BELOW_MIN_RST;
    above_rgb   = ABOVE_MAX_RST;
    for (int i = 0; i < NODES; i++) begin
      node_pos[SLOT_W'(i)] = '0;
      node_rgb[SLOT_W'(i)] = '0;
    end

    // ramp from black to white over the full range
    dir_q.push_back(wr_row(4'd0, 8'd0, 24'h000000));
    dir_q.push_back(wr_row(4'd1, 8'd255, 24'hFFFFFF));
    dir_q.push_back(lk_is(8'd0, 24'h000000, 1'b1));
    dir_q.push_back(lk_is(8'd255, 24'hFFFFFF, 1'b1));
    dir_q.push_back(lk_row(8'd128));
    dir_q.push_back(lk_row(8'd1));
    dir_q.push_back(lk_row(8'd254));
    // marker segments
    dir_q.push_back(wr_row(4'd0, 8'd0, MARK_A));
    dir_q.push_back(wr_row(4'd1, 8'd255, MARK_A));
    dir_q.push_back(lk_is(8'd100, MARK_A, 1'b0));
    dir_q.push_back(lk_is(8'd255, MARK_A, 1'b0));
    dir_q.push_back(wr_row(4'd1, 8'd255, MARK_B));
    dir_q.push_back(lk_row(8'd100));
    dir_q.push_back(lk_is(8'd255, MARK_B, 1'b0));
    // coincident nodes
    dir_q.push_back(wr_row(4'd0, 8'd10, 24'h102030));
    dir_q.push_back(wr_row(4'd1, 8'd10, 24'h405060));
    dir_q.push_back(lk_is(8'd5, 24'h102030, 1'b1));
    dir_q.push_back(lk_is(8'd10, 24'h405060, 1'b1));
    // unsorted nodes leave an index uncovered
    dir_q.push_back(wr_row(4'd0, 8'd200, 24'hA0B0C0));
    dir_q.push_back(wr_row(4'd1, 8'd50, 24'hAABBCC));
    dir_q.push_back(lk_is(8'd20, 24'hA0B0C0, 1'b1));
    dir_q.push_back(lk_is(8'd100, 24'hAABBCC, 1'b1));
    dir_q.push_back(cfg_row(CFG_EXTREME_EN, 24'd1));
    dir_q.push_back(cfg_row(CFG_BELOW_MIN, 24'h123456));
    dir_q.push_back(cfg_row(CFG_ABOVE_MAX, 24'hABCDEF));
    dir_q.push_back(lk_is(8'd0, 24'h123456, 1'b1));
    dir_q.push_back(lk_is(8'd255, 24'hABCDEF, 1'b1));
    dir_q.push_back(cfg_row(CFG_EXTREME_EN, 24'd0));
    dir_q.push_back(cfg_row(CFG_NODE_COUNT, 24'd1));
    dir_q.push_back(lk_is(8'd7, 24'hA0B0C0, 1'b1));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_q[r]) begin
      if (dir_q[r].kind == ROW_CFG) begin
        cfg_write(dir_q[r].cfg_idx, dir_q[r].cfg_data);
      end else begin
        pace();
        send_item(dir_q[r].it, dir_q[r].typed, dir_q[r].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       nc = 5'd0;
        1:       nc = 5'd16;
        2:       nc = 5'd1;
        3:       nc = 5'd31;
        4:       nc = 5'd2;
        5:       nc = 5'd17;
        default: nc = 5'($urandom_range(3, 15));
      endcase
      lo_rgb = CFG_DATA_W'($urandom);
      hi_rgb = CFG_DATA_W'($urandom);
      if (ph == 0) begin
        lo_rgb = 24'h000000;
        hi_rgb = 24'hFFFFFF;
      end else if (ph == 1) begin
        lo_rgb = 24'hFFFFFF;
        hi_rgb = 24'h000000;
      end
      gaps_on = (ph != 2) && (ph != 5);
      wd      = CFG_DATA_W'($urandom);
      wd[4:0] = nc;
      cfg_write(CFG_NODE_COUNT, wd);
      wd    = CFG_DATA_W'($urandom);
      wd[0] = (ph % 3 != 1);
      cfg_write(CFG_EXTREME_EN, wd);
      cfg_write(CFG_BELOW_MIN, lo_rgb);
      cfg_write(CFG_ABOVE_MAX, hi_rgb);

      // sorted store with random content before any lookup
      p = $urandom_range(0, 12);
      for (int s = 0; s < NODES; s++) begin
        it      = rand_item();
        it.mode = MODE_WRITE;
        it.node_slot     = 4'(s);
        it.node_position = 8'(p);
        {it.node_red, it.node_green, it.node_blue} =
          pick_color(s == 0 ? COLOR_W'($urandom) : node_rgb[SLOT_W'(s-1)]);
        pace();
        send_item(it, 1'b0, none);
        p = p + $urandom_range(0, 24);
        if (p > 255) p = 255;
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 59) == 0) wait_drained();
        pace();
        send_item(rand_item(), 1'b0, none);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES + 4) @(posedge clk_i);
    if (color_q.size() != 0) report_mismatch("results never returned", 0, color_q.size());
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
